// ===== rtl/tmt_pkg.sv =====
// Shared types, constants and step functions of the TinyMT32 generator.
package tmt_pkg;

    // Generator state: four 32-bit words, word 0 in the lowest bits.
    typedef logic [3:0][31:0] t_state;

    // Reset values of the parameter registers.
    localparam logic [31:0] MAT1_RESET   = 32'h8f70_11ee;
    localparam logic [31:0] MAT2_RESET   = 32'hfc78_ff1f;
    localparam logic [31:0] TEMPER_RESET = 32'h3793_fdff;

    // Seeding constants.
    localparam logic [31:0] SEED_MULT  = 32'd1812433253;
    localparam logic [31:0] LOW31_MASK = 32'h7fff_ffff;
    localparam logic [31:0] CHAR_T     = 32'h0000_0054;
    localparam logic [31:0] CHAR_I     = 32'h0000_0049;
    localparam logic [31:0] CHAR_N     = 32'h0000_004e;
    localparam logic [31:0] CHAR_Y     = 32'h0000_0059;

    localparam int MixRounds   = 8;
    localparam int WarmupSteps = 8;
    localparam int RoundW      = 3;

    // Item kinds carried in the input tuser bit.
    localparam logic MODE_SEED = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAT1   = 2'd0;
    localparam logic [1:0] CFG_MAT2   = 2'd1;
    localparam logic [1:0] CFG_TEMPER = 2'd2;
    localparam logic [1:0] CFG_LINEAR = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              mul;
        logic              mix;
        logic              fix;
        logic              step;
        logic              draw;
        logic [RoundW-1:0] round;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // One state transition of the generator.
    function automatic t_state tmt_advance(input t_state st, input logic [31:0] mat1,
                                           input logic [31:0] mat2);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] sel;
        t_state      nx;
        x = (st[0] & LOW31_MASK) ^ st[1] ^ st[2];
        y = st[3];
        x = x ^ (x << 1);
        y = y ^ (y >> 1) ^ x;
        sel = {32{y[0]}};
        nx[0] = st[1];
        nx[1] = st[2] ^ (sel & mat1);
        nx[2] = x ^ (y << 10) ^ (sel & mat2);
        nx[3] = y;
        return nx;
    endfunction

    // Output tempering of a state.
    function automatic logic [31:0] tmt_temper(input t_state st, input logic [31:0] tmat,
                                               input logic linear);
        logic [31:0] shifted;
        logic [31:0] t1;
        logic [31:0] t0;
        shifted = st[2] >> 8;
        t1 = linear ? (st[0] ^ shifted) : (st[0] + shifted);
        t0 = st[3] ^ t1;
        if (t1[0]) begin
            t0 = t0 ^ tmat;
        end
        return t0;
    endfunction

endpackage

// ===== rtl/tmt_ctrl.sv =====
// Sequencing controller for seeding and draws.
module tmt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_mode,
    input  tmt_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output tmt_pkg::t_dp_cmd    o_cmd
);
    import tmt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MIX,
        ST_FIX,
        ST_WARM
    } t_ctrl_state;

    localparam logic [RoundW-1:0] LastRound = RoundW'(MixRounds - 1);
    localparam logic [RoundW-1:0] LastWarm  = RoundW'(WarmupSteps - 1);

    t_ctrl_state       r_state;
    t_ctrl_state       n_state;
    logic [RoundW-1:0] r_round;
    logic [RoundW-1:0] n_round;
    logic [RoundW-1:0] r_warm;
    logic [RoundW-1:0] n_warm;
    logic              w_fire;

    // Items are taken only when idle and the result register can take a value.
    assign o_in_ready = (r_state == ST_IDLE) && i_status.out_free;
    assign w_fire     = o_in_ready && i_in_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_warm      = r_warm;
        o_cmd       = '0;
        o_cmd.round = r_round;
        case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    if (i_in_mode == MODE_SEED) begin
                        o_cmd.load = 1'b1;
                        n_round    = RoundW'(1);
                        n_state    = ST_MUL;
                    end else begin
                        o_cmd.draw = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_MIX;
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                if (r_round == LastRound) begin
                    n_state = ST_FIX;
                end else begin
                    n_round = r_round + RoundW'(1);
                    n_state = ST_MUL;
                end
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_warm    = '0;
                n_state   = ST_WARM;
            end
            ST_WARM: begin
                o_cmd.step = 1'b1;
                n_warm     = r_warm + RoundW'(1);
                if (r_warm == LastWarm) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
            r_warm  <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_warm  <= n_warm;
        end
    end

endmodule

// ===== rtl/tmt_datapath.sv =====
// State words, parameter registers, seed multiplier and result register.
module tmt_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tmt_pkg::t_dp_cmd    i_cmd,
    input  logic [31:0]         i_seed,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [31:0]         o_out_data,
    output tmt_pkg::t_dp_status o_status
);
    import tmt_pkg::*;

    t_state      r_w;
    t_state      n_w;
    t_state      w_adv;
    t_state      w_rot;
    logic [31:0] r_mat1;
    logic [31:0] r_mat2;
    logic [31:0] r_tmat;
    logic        r_linear;
    logic [31:0] r_prod;
    logic [31:0] w_mix_in;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        w_zero;

    assign w_adv    = tmt_advance(r_w, r_mat1, r_mat2);
    assign w_mix_in = r_w[0] ^ (r_w[0] >> 30);

    // After seven rotating mix rounds, word k sits at position k+1 mod 4.
    assign w_rot  = {r_w[0], r_w[3], r_w[2], r_w[1]};
    assign w_zero = ((w_rot[0] & LOW31_MASK) == '0) && (w_rot[1] == '0) &&
                    (w_rot[2] == '0) && (w_rot[3] == '0);

    // Next state words.
    always_comb begin
        n_w = r_w;
        if (i_cmd.load) begin
            n_w = {r_tmat, r_mat2, r_mat1, i_seed};
        end else if (i_cmd.mix) begin
            // The updated word moves to position 0 so the next round reads it there.
            n_w[0] = r_w[1] ^ (32'(i_cmd.round) + r_prod);
            n_w[1] = r_w[2];
            n_w[2] = r_w[3];
            n_w[3] = r_w[0];
        end else if (i_cmd.fix) begin
            n_w = w_zero ? {CHAR_Y, CHAR_N, CHAR_I, CHAR_T} : w_rot;
        end else if (i_cmd.step || i_cmd.draw) begin
            n_w = w_adv;
        end
    end

    // Generator state, parameter registers and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w         <= '0;
            r_mat1      <= MAT1_RESET;
            r_mat2      <= MAT2_RESET;
            r_tmat      <= TEMPER_RESET;
            r_linear    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_w <= n_w;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MAT1:   r_mat1   <= i_cfg_data;
                    CFG_MAT2:   r_mat2   <= i_cfg_data;
                    CFG_TEMPER: r_tmat   <= i_cfg_data;
                    CFG_LINEAR: r_linear <= i_cfg_data[0];
                    default:    r_linear <= r_linear;
                endcase
            end
            if (i_cmd.draw) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Seed product and result value.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= SEED_MULT * w_mix_in;
        end
        if (i_cmd.draw) begin
            r_out_data <= tmt_temper(w_adv, r_tmat, r_linear);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

// ===== rtl/tinymt32_generator.sv =====
// Top level of the TinyMT32 pseudorandom generator.
//
//   Channel     Direction  Payload
//   s_axis      in         tdata[31:0] seed, tuser[0] mode (0 seed, 1 draw)
//   m_axis      out        tdata[31:0] value
//   i_cfg_*     in         index 0 mat1, 1 mat2, 2 tmat, 3 linear flag
//
// A draw is taken and its value shows on m_axis the next cycle;
// draws can follow every cycle while the result register drains.
// After its transfer a seed holds the input off for seven mixing rounds,
// each a multiply and a mix step around the registered multiplier, a period
// check and eight warm-up steps. A seed gives no result.
// Reset clears the state to zero and loads the default parameters.
// A stalled result holds the input off for any item, seeds included,
// until the result register is free again.
module tinymt32_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seed
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);
    import tmt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    tmt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_seed      (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_status    (w_status)
    );

endmodule

// ===== rtl/tmt_checker.sv =====
// Port-level checks of the TinyMT32 generator and their binding.
module tmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import tmt_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A draw transfer always yields a result on the next cycle.
    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_DRAW) |=> m_axis_tvalid)
        else $error("draw gave no result");

    // A seed transfer keeps the input closed while seeding runs.
    a_seed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_SEED) |=> !s_axis_tready)
        else $error("input open during seeding");

    // A seed transfer produces no result.
    a_seed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_SEED) && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("seed produced a result");

endmodule

bind tinymt32_generator tmt_checker u_tmt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/tinymt32_generator_tb.sv =====
// Self-checking TinyMT32 generator bench: directed rows, parameter extremes, zero-state seeds, random config phases.
`timescale 1ns / 100ps

module tinymt32_generator_tb;
    import tmt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned SEED_BUSY   = 32;   // Cycles a seed keeps the block busy, rounded up.
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned MAX_REPORTS = 40;
    localparam int          DIR_COUNT   = 23;

    // One directed row: mode, seed, whether the value is known up front, and that value.
    typedef struct packed {
        logic        mode;
        logic [31:0] seed;
        logic        known;
        logic [31:0] value;
    } t_dir_row;

    // Draws before any seed give zero; the rest are checked against the predictor.
    localparam t_dir_row DIRECTED_ROWS [DIR_COUNT] = '{
        '{MODE_DRAW, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{MODE_DRAW, 32'hffff_ffff, 1'b1, 32'h0000_0000},
        '{MODE_SEED, 32'h0000_0000, 1'b0, 32'h0},
        '{MODE_DRAW, 32'ha5a5_a5a5, 1'b0, 32'h0},
        '{MODE_DRAW, 32'h0000_0000, 1'b0, 32'h0},
        '{MODE_SEED, 32'hffff_ffff, 1'b0, 32'h0},
        '{MODE_DRAW, 32'hffff_ffff, 1'b0, 32'h0},
        '{MODE_DRAW, 32'h0000_0000, 1'b0, 32'h0},
        '{MODE_SEED, 32'h8000_0000, 1'b0, 32'h0},
        '{MODE_DRAW, 32'h5a5a_5a5a, 1'b0, 32'h0},
        '{MODE_SEED, 32'h7fff_ffff, 1'b0, 32'h0},
        '{MODE_DRAW, 32'h0000_0000, 1'b0, 32'h0},
        '{MODE_SEED, 32'haaaa_aaaa, 1'b0, 32'h0},
        '{MODE_DRAW, 32'h5555_5555, 1'b0, 32'h0},
        '{MODE_SEED, 32'h5555_5555, 1'b0, 32'h0},
        '{MODE_DRAW, 32'haaaa_aaaa, 1'b0, 32'h0},
        '{MODE_SEED, 32'h0000_0001, 1'b0, 32'h0},
        '{MODE_DRAW, 32'h0000_0000, 1'b0, 32'h0},
        '{MODE_DRAW, 32'hffff_ffff, 1'b0, 32'h0},
        '{MODE_SEED, 32'h0000_0000, 1'b0, 32'h0},
        '{MODE_SEED, 32'h1234_5678, 1'b0, 32'h0},
        '{MODE_DRAW, 32'h0000_0000, 1'b0, 32'h0},
        '{MODE_DRAW, 32'h0000_0000, 1'b0, 32'h0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] seed
    logic        s_axis_tuser  = 1'b0;  // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] value
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = '0;
    logic [31:0] i_cfg_data    = '0;

    // Predictor copy of the generator state and of the parameter registers.
    t_state      twist_words = '0;
    logic [31:0] fb_mat1     = MAT1_RESET;
    logic [31:0] fb_mat2     = MAT2_RESET;
    logic [31:0] out_tmat    = TEMPER_RESET;
    logic        out_linear  = 1'b0;

    logic [31:0] draw_values [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sink_wait   = 0;
    int unsigned hold_asked  = 0;
    int unsigned hold_served = 0;
    bit          drain_calm  = 1'b0;
    bit          push_calm   = 1'b0;

    tinymt32_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Random idle length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Term that one seeding round XORs into the next word.
    function automatic logic [31:0] mix_term(input logic [31:0] prev, input int r);
        return 32'(r) + SEED_MULT * (prev ^ (prev >> 30));
    endfunction

    // One recurrence step of the predictor state.
    function automatic void twist_once();
        logic [31:0] x;
        logic [31:0] y;
        x = (twist_words[0] & LOW31_MASK) ^ twist_words[1] ^ twist_words[2];
        x = x ^ (x << 1);
        y = twist_words[3] ^ (twist_words[3] >> 1) ^ x;
        twist_words[0] = twist_words[1];
        twist_words[1] = twist_words[2];
        twist_words[2] = x ^ (y << 10);
        twist_words[3] = y;
        if (y[0]) begin
            twist_words[1] = twist_words[1] ^ fb_mat1;
            twist_words[2] = twist_words[2] ^ fb_mat2;
        end
    endfunction

    // Output value of the current predictor state.
    function automatic logic [31:0] tempered_value();
        logic [31:0] combo;
        logic [31:0] result;
        if (out_linear) begin
            combo = twist_words[0] ^ (twist_words[2] >> 8);
        end else begin
            combo = twist_words[0] + (twist_words[2] >> 8);
        end
        result = twist_words[3] ^ combo;
        if (combo[0]) begin
            result = result ^ out_tmat;
        end
        return result;
    endfunction

    // Seeding: load, mix, period check, warm-up.
    function automatic void seed_twister(input logic [31:0] seed_val);
        int r;
        twist_words[0] = seed_val;
        twist_words[1] = fb_mat1;
        twist_words[2] = fb_mat2;
        twist_words[3] = out_tmat;
        for (r = 1; r < MixRounds; r++) begin
            twist_words[r & 3] = twist_words[r & 3] ^ mix_term(twist_words[(r - 1) & 3], r);
        end
        if ((twist_words[0] & LOW31_MASK) == '0 && twist_words[1] == '0 &&
            twist_words[2] == '0 && twist_words[3] == '0) begin
            twist_words[0] = CHAR_T;
            twist_words[1] = CHAR_I;
            twist_words[2] = CHAR_N;
            twist_words[3] = CHAR_Y;
        end
        for (r = 0; r < WarmupSteps; r++) begin
            twist_once();
        end
    endfunction

    // Seed and parameters whose mixing ends in a state that is zero outside bit 31.
    // The rounds are undone one by one, since each leaves its source word alone.
    function automatic t_state zero_state_preimage(input logic top_bit);
        t_state w;
        int     r;
        w = '0;
        w[0][31] = top_bit;
        for (r = MixRounds - 1; r >= 1; r--) begin
            w[r & 3] = w[r & 3] ^ mix_term(w[(r - 1) & 3], r);
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // Writes all four parameter registers, one per cycle, and mirrors them.
    task automatic apply_config(input logic [31:0] mat1, input logic [31:0] mat2,
                                input logic [31:0] tmat, input logic [31:0] linear);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_MAT1;
        i_cfg_data <= mat1;
        @(posedge i_clk);
        i_cfg_addr <= CFG_MAT2;
        i_cfg_data <= mat2;
        @(posedge i_clk);
        i_cfg_addr <= CFG_TEMPER;
        i_cfg_data <= tmat;
        @(posedge i_clk);
        i_cfg_addr <= CFG_LINEAR;
        i_cfg_data <= linear;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        fb_mat1    = mat1;
        fb_mat2    = mat2;
        out_tmat   = tmat;
        out_linear = linear[0];
    endtask

    // Offers one item, waits for its transfer and records the value it must produce.
    task automatic offer_item(input logic mode, input logic [31:0] seed_val,
                              input logic known, input logic [31:0] known_val);
        int unsigned gap;
        logic [31:0] want;
        gap = push_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= seed_val;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (mode == MODE_DRAW) begin
            twist_once();
            want = known ? known_val : tempered_value();
            draw_values.push_back(want);
        end else begin
            seed_twister(seed_val);
        end
    endtask

    // Waits until every draw has come back and any seed in flight has finished.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (draw_values.size() != 0) @(posedge i_clk);
        repeat (SEED_BUSY) @(posedge i_clk);
    endtask

    // Mostly draws with an occasional reseed; a few draws may lead before any seed.
    task automatic run_random_phase(input int unsigned count, input int unsigned seed_pct);
        int unsigned lead;
        int unsigned k;
        logic        mode;
        lead = $urandom_range(4, 0);
        for (k = 0; k < count; k++) begin
            if (k < lead || $urandom_range(99, 0) >= seed_pct) begin
                mode = MODE_DRAW;
            end else begin
                mode = MODE_SEED;
            end
            offer_item(mode, $urandom, 1'b0, 32'h0);
        end
    endtask

    // Result side pacing, with a long hold-off on request.
    always @(posedge i_clk) begin : sink_pacing
        int unsigned gap;
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            sink_wait = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait = sink_wait - 1;
            m_axis_tready <= 1'b0;
        end else begin
            gap = drain_calm ? 0 : pick_gap();
            if (gap > 0) begin
                sink_wait = gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Every result transfer is compared with the oldest expected value.
    always @(posedge i_clk) begin : check_results
        logic [31:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (draw_values.size() == 0) begin
                report_mismatch($sformatf("value %h with no draw pending", m_axis_tdata));
            end else begin
                want = draw_values.pop_front();
                if (m_axis_tdata !== want) begin
                    report_mismatch($sformatf("value got %h, expected %h",
                                              m_axis_tdata, want));
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tinymt32_generator_tb: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        int     n;
        int     ph;
        t_state pre;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset parameters.
        for (n = 0; n < DIR_COUNT; n++) begin
            offer_item(DIRECTED_ROWS[n].mode, DIRECTED_ROWS[n].seed,
                       DIRECTED_ROWS[n].known, DIRECTED_ROWS[n].value);
        end
        settle_block();

        // Parameter extremes.
        apply_config(32'h0, 32'h0, 32'h0, 32'h0);
        run_random_phase(60, 10);
        settle_block();
        apply_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        run_random_phase(60, 10);
        settle_block();

        // Seeds whose mixed state is zero under the mask, with bit 31 clear and set.
        for (n = 0; n < 2; n++) begin
            pre = zero_state_preimage(n[0]);
            apply_config(pre[1], pre[2], pre[3], $urandom);
            offer_item(MODE_SEED, pre[0], 1'b0, 32'h0);
            repeat (12) offer_item(MODE_DRAW, $urandom, 1'b0, 32'h0);
            settle_block();
        end

        // Random parameter phases: one with no idling, one with a long result hold-off.
        for (ph = 0; ph < 9; ph++) begin
            push_calm = (ph == 3) || (ph == 6);
            drain_calm <= (ph == 3);
            apply_config($urandom, $urandom, $urandom, $urandom);
            if (ph == 6) begin
                hold_asked <= hold_asked + 1;
            end
            run_random_phase(70, (ph == 6) ? 2 : 9);
            settle_block();
        end
        push_calm = 1'b0;

        if (error_count == 0) begin
            $display("tinymt32_generator_tb: done, clean");
        end else begin
            $display("tinymt32_generator_tb: done, errors");
        end
        $finish;
    end

endmodule
